// File: rtl/bclp_pkg.sv
package bclp_pkg;

    // slot age is a saturating counter
    localparam int AGE_BITS = 16;

    typedef logic [AGE_BITS-1:0] age_t;

    localparam age_t AGE_MAX = '1;

    typedef enum logic [2:0] {
        REQ_READ      = 3'd0,
        REQ_WRITE     = 3'd1,
        REQ_FIX       = 3'd2,
        REQ_UNFIX     = 3'd3,
        REQ_UNFIX_ALL = 3'd4,
        REQ_FLUSH     = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_USED  = 2'd1,
        MODE_FIXED = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_NOSLOT = 2'd2
    } status_t;

    // strobes from the sequencer to the slot store
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic age_we;
        logic mode_we;
        logic unfix_all;
    } mem_ctl_t;

    // verdict of the scan compare unit for one slot
    typedef struct packed {
        logic occupied;
        logic match;
        logic older;
    } cmp_flags_t;

endpackage

// File: rtl/bclp_slot_store.sv
module bclp_slot_store
    import bclp_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int INDEX_BITS = 20,
    parameter int SLOT_BITS  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mem_ctl_t              ctl,
    input  logic [SLOT_BITS-1:0]  rd_addr,
    input  logic [SLOT_BITS-1:0]  wr_addr,
    input  logic [INDEX_BITS-1:0] wr_tag,
    input  age_t                  wr_age,
    input  mode_t                 mode_wdata,
    output mode_t [SLOTS-1:0]     modes,
    output logic [INDEX_BITS-1:0] rd_tag,
    output age_t                  rd_age
);

    // tag and age are only meaningful while the slot is occupied
    logic [INDEX_BITS-1:0] tag_mem [SLOTS];
    age_t                  age_mem [SLOTS];
    logic [INDEX_BITS-1:0] rd_tag_reg;
    age_t                  rd_age_reg;

    mode_t [SLOTS-1:0] mode_reg;
    mode_t [SLOTS-1:0] mode_next;

    always_ff @(posedge clk)
    begin
        if (ctl.tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (ctl.age_we)
        begin
            age_mem[wr_addr] <= wr_age;
        end
        if (ctl.rd_en)
        begin
            rd_tag_reg <= tag_mem[rd_addr];
            rd_age_reg <= age_mem[rd_addr];
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (ctl.unfix_all)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (mode_reg[i] == MODE_FIXED)
                begin
                    mode_next[i] = MODE_USED;
                end
            end
        end
        else if (ctl.mode_we)
        begin
            mode_next[wr_addr] = mode_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i] <= MODE_FREE;
            end
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign modes  = mode_reg;
    assign rd_tag = rd_tag_reg;
    assign rd_age = rd_age_reg;

endmodule

// File: rtl/bclp_scan_cmp.sv
module bclp_scan_cmp
    import bclp_pkg::*;
#(
    parameter int INDEX_BITS = 20
)
(
    input  mode_t                 mode,
    input  logic [INDEX_BITS-1:0] tag,
    input  logic [INDEX_BITS-1:0] key,
    input  age_t                  age,
    input  age_t                  best_age,
    input  logic                  best_found,
    output cmp_flags_t            flags,
    output age_t                  age_next
);

    always_comb
    begin
        flags.occupied = (mode != MODE_FREE);
        flags.match    = (mode != MODE_FREE) && (tag == key);
        // strictly older keeps the lowest slot on ties
        flags.older    = (mode == MODE_USED) && (!best_found || (age > best_age));
        age_next       = (age == AGE_MAX) ? age : age + 1'b1;
    end

endmodule

// File: rtl/block_cache_lru_pinning_unit.sv
// Slot manager of a block buffer cache. Each request item (read, write, fix, unfix,
// unfix all, flush) is taken when in_ready is high; in_ready stays low until the
// request's last result item has been loaded into the output register, so one
// request is in flight at a time, while the previous result may still wait on
// out_ready. A single scan unit walks the slot store one slot per cycle through a
// registered read port: a hit ends the lookup scan at the hit slot, a miss into a
// free slot takes one full pass, a miss that evicts takes two full passes,
// since the age scan for the victim is a second pass over the store. Unfix all and
// out-of-range or unknown requests are answered without a scan. Flush walks the
// slots up to the last occupied one and gives one result item per occupied
// slot. block_count is written through the cfg channel, which is always ready.
module block_cache_lru_pinning_unit
    import bclp_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int INDEX_BITS = 20,
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_BITS  = $clog2(SLOTS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // block count register
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INDEX_BITS:0]   cfg_data,
    // request items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            req_type,
    input  logic [INDEX_BITS-1:0] block_index,
    // result items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  hit,
    output logic                  slot_valid,
    output logic [SLOT_BITS-1:0]  slot,
    output logic                  fetch,
    output logic                  writeback_valid,
    output logic [INDEX_BITS-1:0] writeback_block,
    output logic                  last
);

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
    localparam logic [CNT_BITS-1:0]  SCAN_END  = CNT_BITS'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_VICT,
        S_FILL,
        S_RESP,
        S_FL_RD,
        S_FL_EMIT
    } state_t;

    // circular successor of a slot number
    function automatic logic [SLOT_BITS-1:0] slot_wrap(input logic [SLOT_BITS-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    state_t state_reg, state_next;

    // request being served
    logic [2:0]            req_reg, req_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [INDEX_BITS:0]   blk_count_reg, blk_count_next;
    logic [SLOT_BITS-1:0]  ptr_reg, ptr_next;

    // scan: issue counter plus one slot in evaluation behind the read port
    logic [CNT_BITS-1:0]   iss_reg, iss_next;
    logic                  ev_vld_reg, ev_vld_next;
    logic [SLOT_BITS-1:0]  ev_idx_reg, ev_idx_next;

    // first free slot after the rotate pointer, above and below it
    logic                  free_hi_vld_reg, free_hi_vld_next, free_hi_vld_c;
    logic [SLOT_BITS-1:0]  free_hi_reg, free_hi_next, free_hi_c;
    logic                  free_lo_vld_reg, free_lo_vld_next, free_lo_vld_c;
    logic [SLOT_BITS-1:0]  free_lo_reg, free_lo_next, free_lo_c;

    // oldest unfixed slot seen so far
    logic                  vic_found_reg, vic_found_next, vic_found_c;
    logic [SLOT_BITS-1:0]  vic_idx_reg, vic_idx_next, vic_idx_c;
    age_t                  vic_age_reg, vic_age_next, vic_age_c;
    logic [INDEX_BITS-1:0] vic_tag_reg, vic_tag_next, vic_tag_c;

    // pending result of a single-result request
    status_t               res_status_reg, res_status_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  res_sv_reg, res_sv_next;
    logic [SLOT_BITS-1:0]  res_slot_reg, res_slot_next;
    logic                  res_fetch_reg, res_fetch_next;
    logic                  res_wbv_reg, res_wbv_next;
    logic [INDEX_BITS-1:0] res_wbb_reg, res_wbb_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic                  hit_reg, hit_next;
    logic                  sv_reg, sv_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic                  fetch_reg, fetch_next;
    logic                  wbv_reg, wbv_next;
    logic [INDEX_BITS-1:0] wbb_reg, wbb_next;
    logic                  last_reg, last_next;

    // slot store and scan unit hookup
    mem_ctl_t              ctl;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [INDEX_BITS-1:0] wr_tag;
    age_t                  wr_age;
    mode_t                 mode_wdata;
    mode_t [SLOTS-1:0]     mode_vec;
    logic [INDEX_BITS-1:0] rd_tag;
    age_t                  rd_age;
    cmp_flags_t            flags;
    age_t                  age_next;

    logic [SLOT_BITS-1:0]  iss_idx;
    logic                  iss_done;
    logic                  is_last_ev;
    logic                  req_is_unfix;
    logic                  out_free;
    logic                  occ_above;

    bclp_slot_store #(
        .SLOTS      (SLOTS),
        .INDEX_BITS (INDEX_BITS),
        .SLOT_BITS  (SLOT_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_tag     (wr_tag),
        .wr_age     (wr_age),
        .mode_wdata (mode_wdata),
        .modes      (mode_vec),
        .rd_tag     (rd_tag),
        .rd_age     (rd_age)
    );

    // the one compare/age unit shared by lookup, unfix and victim scans
    bclp_scan_cmp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_cmp (
        .mode       (mode_vec[ev_idx_reg]),
        .tag        (rd_tag),
        .key        (idx_reg),
        .age        (rd_age),
        .best_age   (vic_age_reg),
        .best_found (vic_found_reg),
        .flags      (flags),
        .age_next   (age_next)
    );

    assign iss_idx      = iss_reg[SLOT_BITS-1:0];
    assign iss_done     = (iss_reg == SCAN_END);
    assign is_last_ev   = (ev_idx_reg == LAST_SLOT);
    assign req_is_unfix = (req_reg == REQ_UNFIX);
    assign out_free     = !out_valid_reg || out_ready;

    // any occupied slot beyond the one being flushed decides the last flag
    always_comb
    begin
        occ_above = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if ((mode_vec[j] != MODE_FREE) && (SLOT_BITS'(j) > iss_idx))
            begin
                occ_above = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        blk_count_next   = blk_count_reg;
        ptr_next         = ptr_reg;
        iss_next         = iss_reg;
        ev_vld_next      = ev_vld_reg;
        ev_idx_next      = ev_idx_reg;
        free_hi_vld_c    = free_hi_vld_reg;
        free_hi_c        = free_hi_reg;
        free_lo_vld_c    = free_lo_vld_reg;
        free_lo_c        = free_lo_reg;
        vic_found_c      = vic_found_reg;
        vic_idx_c        = vic_idx_reg;
        vic_age_c        = vic_age_reg;
        vic_tag_c        = vic_tag_reg;
        res_status_next  = res_status_reg;
        res_hit_next     = res_hit_reg;
        res_sv_next      = res_sv_reg;
        res_slot_next    = res_slot_reg;
        res_fetch_next   = res_fetch_reg;
        res_wbv_next     = res_wbv_reg;
        res_wbb_next     = res_wbb_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        hit_next         = hit_reg;
        sv_next          = sv_reg;
        slot_next        = slot_reg;
        fetch_next       = fetch_reg;
        wbv_next         = wbv_reg;
        wbb_next         = wbb_reg;
        last_next        = last_reg;

        ctl        = '0;
        rd_addr    = iss_idx;
        wr_addr    = ev_idx_reg;
        wr_tag     = idx_reg;
        wr_age     = age_next;
        mode_wdata = MODE_USED;

        // register write: the user must do it only while idle; the block does not enforce it
        if (cfg_valid)
        begin
            blk_count_next = cfg_data;
        end

        // output register drains independently of the sequencer
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    idx_next   = block_index;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = STAT_OK;
                res_hit_next    = 1'b0;
                res_sv_next     = 1'b0;
                res_slot_next   = '0;
                res_fetch_next  = 1'b0;
                res_wbv_next    = 1'b0;
                res_wbb_next    = '0;
                unique case (req_reg) inside
                    REQ_UNFIX_ALL:
                    begin
                        ctl.unfix_all = 1'b1;
                        state_next    = S_RESP;
                    end
                    REQ_FLUSH:
                    begin
                        iss_next   = '0;
                        state_next = S_FL_RD;
                    end
                    REQ_READ, REQ_WRITE, REQ_FIX, REQ_UNFIX:
                    begin
                        if ({1'b0, idx_reg} >= blk_count_reg)
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            iss_next      = '0;
                            ev_vld_next   = 1'b0;
                            free_hi_vld_c = 1'b0;
                            free_lo_vld_c = 1'b0;
                            state_next    = S_LOOK;
                        end
                    end
                    default:
                    begin
                        // unknown request: a bare last item, no state change
                        state_next = S_RESP;
                    end
                endcase
            end

            S_LOOK:
            begin
                // issue the next slot read while the previous one is evaluated
                if (!iss_done)
                begin
                    ctl.rd_en   = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = iss_idx;
                end
                else
                begin
                    ev_vld_next = 1'b0;
                end

                if (ev_vld_reg)
                begin
                    // track free slots on the way for a possible miss
                    if (mode_vec[ev_idx_reg] == MODE_FREE)
                    begin
                        if ((ev_idx_reg > ptr_reg) && !free_hi_vld_reg)
                        begin
                            free_hi_vld_c = 1'b1;
                            free_hi_c     = ev_idx_reg;
                        end
                        if ((ev_idx_reg < ptr_reg) && !free_lo_vld_reg)
                        begin
                            free_lo_vld_c = 1'b1;
                            free_lo_c     = ev_idx_reg;
                        end
                    end

                    if (flags.match)
                    begin
                        res_hit_next  = 1'b1;
                        res_sv_next   = 1'b1;
                        res_slot_next = ev_idx_reg;
                        ctl.mode_we   = req_is_unfix || (req_reg == REQ_FIX);
                        mode_wdata    = req_is_unfix ? MODE_USED : MODE_FIXED;
                        if (!req_is_unfix)
                        begin
                            // hit slot becomes youngest
                            ctl.age_we = 1'b1;
                            wr_age     = '0;
                        end
                        state_next = S_RESP;
                    end
                    else
                    begin
                        // occupied slots passed by a lookup other than unfix get older
                        if (flags.occupied && !req_is_unfix)
                        begin
                            ctl.age_we = 1'b1;
                        end
                        if (is_last_ev)
                        begin
                            res_fetch_next = (req_reg != REQ_WRITE);
                            if (req_is_unfix)
                            begin
                                res_fetch_next = 1'b0;
                                state_next     = S_RESP;
                            end
                            else if (mode_vec[ptr_reg] == MODE_FREE)
                            begin
                                // free slot at the pointer, pointer moves on
                                res_sv_next   = 1'b1;
                                res_slot_next = ptr_reg;
                                ptr_next      = slot_wrap(ptr_reg);
                                state_next    = S_FILL;
                            end
                            else if (free_hi_vld_c)
                            begin
                                res_sv_next   = 1'b1;
                                res_slot_next = free_hi_c;
                                state_next    = S_FILL;
                            end
                            else if (free_lo_vld_c)
                            begin
                                res_sv_next   = 1'b1;
                                res_slot_next = free_lo_c;
                                state_next    = S_FILL;
                            end
                            else
                            begin
                                // cache full: second pass for the oldest unfixed slot
                                iss_next    = '0;
                                ev_vld_next = 1'b0;
                                vic_found_c = 1'b0;
                                state_next  = S_VICT;
                            end
                        end
                    end
                end
            end

            S_VICT:
            begin
                if (!iss_done)
                begin
                    ctl.rd_en   = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = iss_idx;
                end
                else
                begin
                    ev_vld_next = 1'b0;
                end

                if (ev_vld_reg)
                begin
                    if (flags.older)
                    begin
                        vic_found_c = 1'b1;
                        vic_idx_c   = ev_idx_reg;
                        vic_age_c   = rd_age;
                        vic_tag_c   = rd_tag;
                    end
                    if (is_last_ev)
                    begin
                        if (vic_found_c)
                        begin
                            // evict with writeback, pointer goes past the victim
                            res_sv_next    = 1'b1;
                            res_slot_next  = vic_idx_c;
                            res_fetch_next = (req_reg != REQ_WRITE);
                            res_wbv_next   = 1'b1;
                            res_wbb_next   = vic_tag_c;
                            ptr_next       = slot_wrap(vic_idx_c);
                            state_next     = S_FILL;
                        end
                        else
                        begin
                            // every slot fixed: bypass, write goes straight through
                            res_fetch_next = 1'b0;
                            if (req_reg == REQ_FIX)
                            begin
                                res_status_next = STAT_NOSLOT;
                            end
                            else if (req_reg == REQ_WRITE)
                            begin
                                res_wbv_next = 1'b1;
                                res_wbb_next = idx_reg;
                            end
                            state_next = S_RESP;
                        end
                    end
                end
            end

            S_FILL:
            begin
                // new entry starts at age zero
                ctl.tag_we  = 1'b1;
                ctl.age_we  = 1'b1;
                ctl.mode_we = 1'b1;
                wr_addr     = res_slot_reg;
                wr_age      = '0;
                mode_wdata  = (req_reg == REQ_FIX) ? MODE_FIXED : MODE_USED;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    hit_next       = res_hit_reg;
                    sv_next        = res_sv_reg;
                    slot_next      = res_slot_reg;
                    fetch_next     = res_fetch_reg;
                    wbv_next       = res_wbv_reg;
                    wbb_next       = res_wbb_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_FL_RD:
            begin
                if (iss_done)
                begin
                    // nothing occupied: one empty last item
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STAT_OK;
                        hit_next       = 1'b0;
                        sv_next        = 1'b0;
                        slot_next      = '0;
                        fetch_next     = 1'b0;
                        wbv_next       = 1'b0;
                        wbb_next       = '0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (mode_vec[iss_idx] != MODE_FREE)
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_FL_EMIT;
                end
                else
                begin
                    iss_next = iss_reg + 1'b1;
                end
            end

            S_FL_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    hit_next       = 1'b0;
                    sv_next        = 1'b1;
                    slot_next      = iss_idx;
                    fetch_next     = 1'b0;
                    wbv_next       = 1'b1;
                    wbb_next       = rd_tag;
                    last_next      = !occ_above;
                    if (occ_above)
                    begin
                        iss_next   = iss_reg + 1'b1;
                        state_next = S_FL_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        free_hi_vld_next = free_hi_vld_c;
        free_hi_next     = free_hi_c;
        free_lo_vld_next = free_lo_vld_c;
        free_lo_next     = free_lo_c;
        vic_found_next   = vic_found_c;
        vic_idx_next     = vic_idx_c;
        vic_age_next     = vic_age_c;
        vic_tag_next     = vic_tag_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            idx_reg         <= '0;
            blk_count_reg   <= '0;
            ptr_reg         <= '0;
            iss_reg         <= '0;
            ev_vld_reg      <= 1'b0;
            ev_idx_reg      <= '0;
            free_hi_vld_reg <= 1'b0;
            free_hi_reg     <= '0;
            free_lo_vld_reg <= 1'b0;
            free_lo_reg     <= '0;
            vic_found_reg   <= 1'b0;
            vic_idx_reg     <= '0;
            vic_age_reg     <= '0;
            vic_tag_reg     <= '0;
            res_status_reg  <= STAT_OK;
            res_hit_reg     <= 1'b0;
            res_sv_reg      <= 1'b0;
            res_slot_reg    <= '0;
            res_fetch_reg   <= 1'b0;
            res_wbv_reg     <= 1'b0;
            res_wbb_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STAT_OK;
            hit_reg         <= 1'b0;
            sv_reg          <= 1'b0;
            slot_reg        <= '0;
            fetch_reg       <= 1'b0;
            wbv_reg         <= 1'b0;
            wbb_reg         <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            idx_reg         <= idx_next;
            blk_count_reg   <= blk_count_next;
            ptr_reg         <= ptr_next;
            iss_reg         <= iss_next;
            ev_vld_reg      <= ev_vld_next;
            ev_idx_reg      <= ev_idx_next;
            free_hi_vld_reg <= free_hi_vld_next;
            free_hi_reg     <= free_hi_next;
            free_lo_vld_reg <= free_lo_vld_next;
            free_lo_reg     <= free_lo_next;
            vic_found_reg   <= vic_found_next;
            vic_idx_reg     <= vic_idx_next;
            vic_age_reg     <= vic_age_next;
            vic_tag_reg     <= vic_tag_next;
            res_status_reg  <= res_status_next;
            res_hit_reg     <= res_hit_next;
            res_sv_reg      <= res_sv_next;
            res_slot_reg    <= res_slot_next;
            res_fetch_reg   <= res_fetch_next;
            res_wbv_reg     <= res_wbv_next;
            res_wbb_reg     <= res_wbb_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            hit_reg         <= hit_next;
            sv_reg          <= sv_next;
            slot_reg        <= slot_next;
            fetch_reg       <= fetch_next;
            wbv_reg         <= wbv_next;
            wbb_reg         <= wbb_next;
            last_reg        <= last_next;
        end
    end

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign hit             = hit_reg;
    assign slot_valid      = sv_reg;
    assign slot            = slot_reg;
    assign fetch           = fetch_reg;
    assign writeback_valid = wbv_reg;
    assign writeback_block = wbb_reg;
    assign last            = last_reg;

`ifndef NO_ASSERTIONS
    // one request at a time: an accepted item closes the input
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a request is in flight");

    // a failed fix never names a slot or asks for data movement
    a_noslot_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NOSLOT) |-> !slot_valid && !fetch && !writeback_valid)
        else $error("failed fix carries a slot or transfer");

    // a fill always names a slot and is never a hit
    a_fetch_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fetch |-> slot_valid && !hit)
        else $error("fetch without a slot or on a hit");

    // flush only reads the slot store
    a_flush_readonly: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_RD || state_reg == S_FL_EMIT)
            |-> !ctl.tag_we && !ctl.age_we && !ctl.mode_we && !ctl.unfix_all)
        else $error("slot store written during flush");
`endif

endmodule
